// File: design/gcsf_pkg.sv
// Shared types, codes and opcode decode for the graphics command stream framer.
// No dependencies; used by gcsf_parser, gcsf_outq and the top level.
package gcsf_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  // Record kinds
  localparam logic [1:0] KIND_CMD      = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_END_HDR  = 2'd3;

  localparam logic [7:0] OP_ESCAPE = 8'hff;
  localparam logic [16:0] ESCAPE_HDR_LEN = 17'd5;

  // One result record
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic [15:0] write_len;
    logic [15:0] read_len;
    logic [16:0] step_len;
    logic        last;
  } rec_t;

  // Records produced by one item, first one in slot a
  typedef struct packed {
    logic [1:0] n;
    rec_t       a;
    rec_t       b;
  } push_t;

  // Opcode decode result
  typedef struct packed {
    logic        known;
    logic [2:0]  need;
    logic [15:0] w;
    logic [15:0] r;
  } dec_t;

  // Byte count of a bit row: (width + 7) / 8
  function automatic logic [5:0] row_bytes(input logic [7:0] bits);
    logic [8:0] s;
    s = 9'(bits) + 9'd7;
    return s[8:3];
  endfunction

  // Lengths and header size of an opcode; h0..h3 are header bytes after it
  function automatic dec_t decode(input logic [7:0] op, input logic [7:0] h0,
                                  input logic [7:0] h1, input logic [7:0] h2,
                                  input logic [7:0] h3);
    dec_t d;
    logic [13:0] prod;
    d.known = 1'b1;
    d.need  = 3'd0;
    d.w     = 16'd0;
    d.r     = 16'd0;
    prod    = 14'd0;
    unique case (op)
      8'h20: begin d.need = 3'd1; d.w = 16'(h0) + 16'd1; d.r = 16'(h0) + 16'd1; end
      8'h40, 8'h41, 8'h85: d.w = 16'd1;
      8'h31, 8'h42, 8'h44, 8'h46, 8'h47, 8'h48, 8'h86, 8'h9d, 8'h9f: d.w = 16'd2;
      8'h4a, 8'h73, 8'h75, 8'h94, 8'ha0, 8'h9c, 8'h9e: d.w = 16'd3;
      8'h98: d.w = 16'd4;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
      8'h84: d.w = 16'd5;
      8'h7f, 8'h96, 8'h9a, 8'hba: d.w = 16'd6;
      8'h70, 8'h71, 8'h76, 8'h77, 8'h78, 8'h79: d.w = 16'd7;
      8'h90, 8'h92: d.w = 16'd8;
      8'h50, 8'h51, 8'h6e, 8'h6f, 8'h80: d.w = 16'd9;
      8'h91: d.w = 16'd13;
      8'h83: d.w = 16'd16;
      8'hb0: begin d.w = 16'd1; d.r = 16'd15; end
      8'h6a, 8'h6b, 8'h6c, 8'h6d: begin
        d.need = 3'd1;
        d.w = {6'd0, h0, 2'b00} + 16'd2;
      end
      8'h7c, 8'h7d, 8'h82: begin d.need = 3'd1; d.w = 16'(h0) + 16'd2; end
      8'h95: begin
        d.need = 3'd2;
        prod = 14'(row_bytes(h0)) * 14'(h1);
        d.w = 16'(prod) + 16'd3;
      end
      8'h97: begin d.need = 3'd1; d.w = 16'(row_bytes(h0)) + 16'd3; end
      8'h99: begin
        d.need = 3'd4;
        prod = 14'(row_bytes(h2)) * 14'(h3);
        d.w = 16'(prod) + 16'd4;
      end
      8'h9b: begin d.need = 3'd2; d.w = 16'(h1) + 16'd4; end
      8'h7e, 8'hb9: begin d.w = 16'd5; d.r = 16'd2; end
      8'hb1: begin d.w = 16'd2; d.r = 16'd7; end
      8'hb2: begin d.w = 16'd1; d.r = 16'd8; end
      8'hb3, 8'hb7, 8'hb8: begin d.w = 16'd1; d.r = 16'd5; end
      8'hb4: begin d.w = 16'd1; d.r = 16'd4; end
      8'hb5: begin d.w = 16'd1; d.r = 16'd6; end
      8'hb6: begin d.w = 16'd1; d.r = 16'd13; end
      8'h81: begin d.need = 3'd1; d.w = 16'd2; d.r = 16'(h0) + 16'd2; end
      OP_ESCAPE: begin d.need = 3'd4; d.w = {h1, h0}; d.r = {h3, h2}; end
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// File: design/gcsf_parser.sv
// Parser: input register, framing state and per-item record generation.
// Depends on gcsf_pkg.
module gcsf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        cmd_byte,
  input  logic              last_byte,
  input  logic              room,
  output gcsf_pkg::push_t   push
);

  // Input register
  logic       iv;
  logic [7:0] ib;
  logic       il;
  logic       proc;

  // Framing state
  gcsf_pkg::phase_t phase, phase_next;
  logic [7:0]  held, held_next;
  logic [7:0]  hdr [4];
  logic [7:0]  hdr_sel [4];
  logic [2:0]  idx, idx_next, idx_inc;
  logic [16:0] skip, skip_next, skip_dec;

  logic [7:0]  op_sel;
  gcsf_pkg::dec_t dec;
  logic [16:0] step, taken, fin_step, fin_skip;
  logic [15:0] mx;
  logic        fin;
  logic        has0, has1;
  gcsf_pkg::rec_t rec0, rec1;

  assign proc     = iv & room;
  assign in_stall = iv & ~room;

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!iv || proc) begin
      iv <= in_valid;
    end
    if (!iv || proc) begin
      ib <= cmd_byte;
      il <= last_byte;
    end
  end

  // Decode of current opcode with this byte merged into the header
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hdr_sel[i] = (phase == gcsf_pkg::PH_HEADER && idx[1:0] == 2'(i)) ? ib : hdr[i];
    end
    op_sel = (phase == gcsf_pkg::PH_OPCODE) ? ib : held;
    dec = gcsf_pkg::decode(op_sel, hdr_sel[0], hdr_sel[1], hdr_sel[2], hdr_sel[3]);
    // Step of a finished command, never below the bytes already taken
    mx    = (dec.w > dec.r) ? dec.w : dec.r;
    step  = {1'b0, mx} + ((op_sel == gcsf_pkg::OP_ESCAPE) ? gcsf_pkg::ESCAPE_HDR_LEN : 17'd0);
    taken = 17'(dec.need) + 17'd1;
    fin_step = (step < taken) ? taken : step;
    fin_skip = fin_step - taken;
    idx_inc  = idx + 3'd1;
    skip_dec = (skip != 17'd0) ? skip - 17'd1 : skip;
  end

  // Next state and records
  always_comb begin
    phase_next = phase;
    held_next  = held;
    idx_next   = idx;
    skip_next  = skip;
    fin  = 1'b0;
    has0 = 1'b0;
    has1 = 1'b0;
    rec0 = '0;
    rec1 = '0;
    unique case (phase)
      gcsf_pkg::PH_OPCODE: begin
        held_next = ib;
        idx_next  = 3'd0;
        if (!dec.known) begin
          has0 = 1'b1;
          rec0.kind   = gcsf_pkg::KIND_UNKNOWN;
          rec0.opcode = ib;
          phase_next  = gcsf_pkg::PH_DROP;
        end else if (dec.need == 3'd0) begin
          fin = 1'b1;
        end else begin
          phase_next = gcsf_pkg::PH_HEADER;
        end
      end
      gcsf_pkg::PH_HEADER: begin
        idx_next = idx_inc;
        if (idx_inc >= dec.need) fin = 1'b1;
      end
      gcsf_pkg::PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 17'd0) phase_next = gcsf_pkg::PH_OPCODE;
      end
      gcsf_pkg::PH_DROP: ;
      default: ;
    endcase
    // Command finished
    if (fin) begin
      has0 = 1'b1;
      rec0.kind      = gcsf_pkg::KIND_CMD;
      rec0.opcode    = op_sel;
      rec0.write_len = dec.w;
      rec0.read_len  = dec.r;
      rec0.step_len  = fin_step;
      skip_next  = fin_skip;
      phase_next = (fin_skip != 17'd0) ? gcsf_pkg::PH_SKIP : gcsf_pkg::PH_OPCODE;
      idx_next   = 3'd0;
    end
    // End of buffer
    if (il) begin
      has1 = 1'b1;
      if (phase_next == gcsf_pkg::PH_HEADER) begin
        rec1.kind   = gcsf_pkg::KIND_END_HDR;
        rec1.opcode = held_next;
      end else begin
        rec1.kind = gcsf_pkg::KIND_END;
      end
      phase_next = gcsf_pkg::PH_OPCODE;
      idx_next   = 3'd0;
      skip_next  = 17'd0;
    end
    rec0.last = ~has1;
    rec1.last = 1'b1;
    push.n = proc ? (2'(has0) + 2'(has1)) : 2'd0;
    push.a = has0 ? rec0 : rec1;
    push.b = rec1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= gcsf_pkg::PH_OPCODE;
      held  <= 8'd0;
      idx   <= 3'd0;
      skip  <= 17'd0;
    end else if (proc) begin
      phase <= phase_next;
      held  <= held_next;
      idx   <= idx_next;
      skip  <= skip_next;
    end
  end

  // Header bytes, written as they arrive
  always_ff @(posedge clk) begin
    if (proc && phase == gcsf_pkg::PH_HEADER) begin
      hdr[idx[1:0]] <= ib;
    end
  end

endmodule

// File: design/gcsf_outq.sv
// Four-entry result queue; takes up to two records per cycle, gives one while out_stall is low.
// Depends on gcsf_pkg.
module gcsf_outq (
  input  logic              clk,
  input  logic              rst,
  input  gcsf_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output gcsf_pkg::rec_t    head
);

  gcsf_pkg::rec_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid & ~out_stall;
  assign room      = (count <= 3'd2);
  assign head      = mem[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      count <= 3'd0;
    end else begin
      wp    <= wp + push.n;
      rp    <= rp + 2'(pop);
      count <= count + 3'(push.n) - 3'(pop);
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp] <= push.a;
    if (push.n == 2'd2) mem[wp + 2'd1] <= push.b;
  end

endmodule

// File: design/graphics_command_stream_framer_core.sv
// Graphics command stream framer: one buffer byte per item in, framing records out.
// Path: input register, then parser decode into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while the result queue has room; a byte with two
// records gives them out one at a time, and a four-entry result queue absorbs the difference.
// Reset (rst, synchronous): framer waits for an opcode, queue empty.
// Depends on gcsf_pkg, gcsf_parser, gcsf_outq.
module graphics_command_stream_framer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  cmd_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [7:0]  opcode,
  output logic [15:0] write_len,
  output logic [15:0] read_len,
  output logic [16:0] step_len,
  output logic        last_record
);

  gcsf_pkg::push_t push;
  gcsf_pkg::rec_t  head;
  logic            room;

  gcsf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd_byte  (cmd_byte),
    .last_byte (last_byte),
    .room      (room),
    .push      (push)
  );

  gcsf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Result fields
  assign record_kind = head.kind;
  assign opcode      = head.opcode;
  assign write_len   = head.write_len;
  assign read_len    = head.read_len;
  assign step_len    = head.step_len;
  assign last_record = head.last;

endmodule
